/* rtl/mtcp_pkg.sv */
// Package for the Modbus TCP server frame engine.
// Holds function codes, the queued command type and defaults. No dependencies.
package mtcp_pkg;

    localparam int DEF_STORE_DEPTH    = 65536;
    localparam int DEF_FRAME_BYTES    = 512;
    localparam int DEF_MAX_READ_BITS  = 2000;
    localparam int DEF_MAX_READ_WORDS = 125;

    // MBAP header plus function, address, quantity and byte count
    localparam int HDR_BYTES = 13;
    // loop counter width: largest looped quantity is 8 * 255 coils
    localparam int CNT_W     = 11;

    localparam logic [7:0] FC_RD_COILS  = 8'h01;
    localparam logic [7:0] FC_RD_INPUTS = 8'h02;
    localparam logic [7:0] FC_RD_HOLD   = 8'h03;
    localparam logic [7:0] FC_RD_INREG  = 8'h04;
    localparam logic [7:0] FC_WR_COIL   = 8'h05;
    localparam logic [7:0] FC_WR_REG    = 8'h06;
    localparam logic [7:0] FC_WR_COILS  = 8'h0f;
    localparam logic [7:0] FC_WR_REGS   = 8'h10;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [15:0] tid;
        t_byte       unit;
        t_byte       fc;
        logic [15:0] addr;
        logic [15:0] qty;
        t_byte       nb;
        logic        coil;
        logic        bank;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_sts;

endpackage

/* rtl/modbus_tcp_slave_frame_engine.sv */
// Top level of the Modbus TCP server frame engine.
// Instantiates mtcp_front, mtcp_cmdq and mtcp_back; uses mtcp_pkg.
//
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+----------------------------
//  request  | i_start, i_frame_byte, i_frame_end        | taken when i_start & !o_busy
//  reply    | o_reply_valid, o_reply_bytes/_count/_last | one-cycle strobe, no stall
//  config   | i_cfg_we, i_cfg_server_started            | written when i_cfg_we
//
// Request bytes are taken one per cycle while o_busy is low. After the end of
// a frame that fit the buffer, o_busy is high for one cycle while the frame is
// checked; a good frame is queued (two deep). The back end runs one queued
// command at a time: a write updates the store before its reply is sent; a
// read sends its reply while reading the store. A short final beat may follow
// the previous beat directly.
// After reset the stores are cleared with o_busy high.
module modbus_tcp_slave_frame_engine #(
    parameter int STORE_DEPTH    = mtcp_pkg::DEF_STORE_DEPTH,
    parameter int FRAME_BYTES    = mtcp_pkg::DEF_FRAME_BYTES,
    parameter int MAX_READ_BITS  = mtcp_pkg::DEF_MAX_READ_BITS,
    parameter int MAX_READ_WORDS = mtcp_pkg::DEF_MAX_READ_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    input  logic        i_cfg_we,
    input  logic        i_cfg_server_started,
    output logic        o_busy,
    output logic        o_reply_valid,
    output logic [63:0] o_reply_bytes,
    output logic [3:0]  o_reply_count,
    output logic        o_reply_last
);
    import mtcp_pkg::*;

    logic                    r_started;
    logic                    take, pend, push, rd_en;
    logic [$clog2(FRAME_BYTES):0] rd_addr;
    logic [7:0]              frame_q;
    logic [1:0]              q_count;
    t_cmd                    front_cmd, head_cmd;
    t_back_sts               sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_started <= 1'b1;
        else if (i_cfg_we) r_started <= i_cfg_server_started;
    end

    assign o_busy = pend || (q_count == 2'd2) || sts.clearing;
    assign take   = i_start && !o_busy;

    mtcp_front #(
        .STORE_DEPTH    (STORE_DEPTH),
        .FRAME_BYTES    (FRAME_BYTES),
        .MAX_READ_BITS  (MAX_READ_BITS),
        .MAX_READ_WORDS (MAX_READ_WORDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .i_started    (r_started),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_data    (frame_q),
        .o_pend       (pend),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    mtcp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (sts.pop),
        .o_head  (head_cmd),
        .o_count (q_count)
    );

    mtcp_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_count != 2'd0),
        .i_cmd         (head_cmd),
        .i_frame_q     (frame_q),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_sts         (sts),
        .o_reply_valid (o_reply_valid),
        .o_reply_bytes (o_reply_bytes),
        .o_reply_count (o_reply_count),
        .o_reply_last  (o_reply_last)
    );

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count != 2'd2))
        else $error("command pushed into a full queue");

    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_reply_valid && !o_reply_last) |-> (o_reply_count == 4'd8))
        else $error("short reply beat before the last one");

    a_beat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid |-> ((o_reply_count != 4'd0) && (o_reply_count <= 4'd8)))
        else $error("reply beat byte count out of range");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.clearing |-> (!o_reply_valid && !push))
        else $error("activity during store clearing");

endmodule

/* rtl/mtcp_front.sv */
// Front end: collects request bytes into a two-bank frame buffer and checks
// each finished frame, producing a command. Depends on mtcp_pkg.
module mtcp_front #(
    parameter int STORE_DEPTH    = mtcp_pkg::DEF_STORE_DEPTH,
    parameter int FRAME_BYTES    = mtcp_pkg::DEF_FRAME_BYTES,
    parameter int MAX_READ_BITS  = mtcp_pkg::DEF_MAX_READ_BITS,
    parameter int MAX_READ_WORDS = mtcp_pkg::DEF_MAX_READ_WORDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [7:0]                     i_frame_byte,
    input  logic                           i_frame_end,
    input  logic                           i_started,
    input  logic                           i_rd_en,
    input  logic [$clog2(FRAME_BYTES):0]   i_rd_addr,
    output logic [7:0]                     o_rd_data,
    output logic                           o_pend,
    output logic                           o_push,
    output mtcp_pkg::t_cmd                 o_cmd
);
    import mtcp_pkg::*;

    localparam int FIW = $clog2(FRAME_BYTES);
    localparam int LW  = $clog2(FRAME_BYTES + 1);
    localparam logic [16:0] SD17 = 17'(STORE_DEPTH);

    t_byte           r_fmem [0:(2 << FIW) - 1];
    t_byte           r_rd_data;
    t_byte           r_hdr [HDR_BYTES];
    logic [LW-1:0]   r_fill;
    logic [LW-1:0]   r_len;
    logic            r_ovf;
    logic            r_bank;
    logic            r_pend;

    logic            full;
    logic [15:0]     addr;
    logic [15:0]     qty;
    t_byte           bc;
    t_byte           fc;
    logic [16:0]     len17;
    logic [16:0]     span;
    logic            hdr_ok;
    logic            is12;
    logic            rng_ok;
    logic            addr_ok;
    logic            fn_ok;
    t_byte           nb;

    assign full = (r_fill == LW'(FRAME_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_bank <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (o_push) r_bank <= ~r_bank;
            if (r_pend) r_pend <= 1'b0;
            if (i_take) begin
                if (i_frame_end) begin
                    r_fill <= '0;
                    r_ovf  <= 1'b0;
                    r_pend <= !(r_ovf || full);
                end else if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_frame_end) r_len <= r_fill + 1'b1;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (i_take && r_fill == LW'(i)) r_hdr[i] <= i_frame_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !full) r_fmem[{r_bank, r_fill[FIW-1:0]}] <= i_frame_byte;
        if (i_rd_en) r_rd_data <= r_fmem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_pend    = r_pend;

    // frame check, in the cycle after the last byte is taken
    always_comb begin
        addr    = {r_hdr[8], r_hdr[9]};
        qty     = {r_hdr[10], r_hdr[11]};
        bc      = r_hdr[12];
        fc      = r_hdr[7];
        len17   = 17'(r_len);
        span    = {1'b0, addr} + {1'b0, qty};
        hdr_ok  = (len17 > 17'd7) && (r_hdr[2] == 8'h00) && (r_hdr[3] == 8'h00)
                  && (({1'b0, r_hdr[4], r_hdr[5]} + 17'd6) == len17);
        is12    = (len17 == 17'd12);
        rng_ok  = (span <= SD17);
        addr_ok = ({1'b0, addr} < SD17);
        nb      = '0;
        unique case (fc)
            FC_RD_COILS, FC_RD_INPUTS: begin
                fn_ok = is12 && (qty <= 16'(MAX_READ_BITS)) && rng_ok;
                nb    = 8'((qty + 16'd7) >> 3);
            end
            FC_RD_HOLD, FC_RD_INREG: begin
                fn_ok = is12 && (qty <= 16'(MAX_READ_WORDS)) && rng_ok;
                nb    = {qty[6:0], 1'b0};
            end
            FC_WR_COIL:  fn_ok = is12 && i_started && addr_ok;
            FC_WR_REG:   fn_ok = is12 && addr_ok;
            FC_WR_COILS: fn_ok = (len17 >= 17'd14) && (len17 == ({9'b0, bc} + 17'd13))
                                 && (qty <= {5'b0, bc, 3'b0}) && rng_ok;
            FC_WR_REGS:  fn_ok = (len17 >= 17'd15) && (len17 == ({9'b0, bc} + 17'd13))
                                 && ({qty, 1'b0} == {9'b0, bc}) && rng_ok;
            default:     fn_ok = 1'b0;
        endcase
    end

    assign o_push     = r_pend && hdr_ok && fn_ok;
    assign o_cmd.tid  = {r_hdr[0], r_hdr[1]};
    assign o_cmd.unit = r_hdr[6];
    assign o_cmd.fc   = fc;
    assign o_cmd.addr = addr;
    assign o_cmd.qty  = qty;
    assign o_cmd.nb   = nb;
    assign o_cmd.coil = (r_hdr[10] != 8'h00);
    assign o_cmd.bank = r_bank;

endmodule

/* rtl/mtcp_cmdq.sv */
// Two-entry command queue between the front end and the back end.
// The head stays in place until the back end pops it. Depends on mtcp_pkg.
module mtcp_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtcp_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output mtcp_pkg::t_cmd  o_head,
    output logic [1:0]      o_count
);
    import mtcp_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_cmd;
    end

    assign o_head  = r_q[r_rp];
    assign o_count = r_count;

endmodule

/* rtl/mtcp_back.sv */
// Back end: executes queued commands one at a time on the bit and word stores
// and sends the reply byte by byte in 8-byte beats. Depends on mtcp_pkg.
module mtcp_back #(
    parameter int STORE_DEPTH = mtcp_pkg::DEF_STORE_DEPTH,
    parameter int FRAME_BYTES = mtcp_pkg::DEF_FRAME_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  mtcp_pkg::t_cmd                 i_cmd,
    input  logic [7:0]                     i_frame_q,
    output logic                           o_rd_en,
    output logic [$clog2(FRAME_BYTES):0]   o_rd_addr,
    output mtcp_pkg::t_back_sts            o_sts,
    output logic                           o_reply_valid,
    output logic [63:0]                    o_reply_bytes,
    output logic [3:0]                     o_reply_count,
    output logic                           o_reply_last
);
    import mtcp_pkg::*;

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int FIW = $clog2(FRAME_BYTES);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_W15_RD = 4'd2;
    localparam logic [3:0] S_W15_BT = 4'd3;
    localparam logic [3:0] S_W16_HI = 4'd4;
    localparam logic [3:0] S_W16_LO = 4'd5;
    localparam logic [3:0] S_W16_WR = 4'd6;
    localparam logic [3:0] S_HDR    = 4'd7;
    localparam logic [3:0] S_RB     = 4'd8;
    localparam logic [3:0] S_RW_REQ = 4'd9;
    localparam logic [3:0] S_RW_HI  = 4'd10;
    localparam logic [3:0] S_RW_LO  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic          r_bmem [STORE_DEPTH];
    logic [15:0]   r_wmem [STORE_DEPTH];
    logic          r_bit_q;
    logic [15:0]   r_word_q;

    logic [3:0]       r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [FIW-1:0]   r_fp, n_fp;
    logic [2:0]       r_bno, n_bno;
    logic [3:0]       r_c, n_c;
    t_byte            r_bits, n_bits;
    t_byte            r_hi, n_hi;
    logic [8:0]       r_k, n_k;
    logic [8:0]       r_n, n_n;
    t_byte            r_acc [8];
    t_byte            n_acc [8];
    logic [2:0]       r_acnt, n_acnt;
    logic             r_ovld, n_ovld;
    logic [63:0]      r_obytes, n_obytes;
    logic [3:0]       r_ocnt, n_ocnt;
    logic             r_olast, n_olast;

    logic          b_we, b_wd, b_re;
    logic [AW-1:0] b_wa, b_ra;
    logic          w_we, w_re;
    logic [AW-1:0] w_wa, w_ra;
    logic [15:0]   w_wd;
    logic          put_en, put_last, pop, rd_en, bitv, is_read, is_bits;
    t_byte         put_b, hdr_b, plen;

    assign is_bits = (i_cmd.fc == FC_RD_COILS) || (i_cmd.fc == FC_RD_INPUTS);
    assign is_read = is_bits || (i_cmd.fc == FC_RD_HOLD) || (i_cmd.fc == FC_RD_INREG);
    assign plen    = is_read ? i_cmd.nb + 8'd3 : 8'd6;
    assign put_last = (r_k == r_n - 9'd1);

    always_comb begin
        unique case (r_k)
            9'd0:    hdr_b = i_cmd.tid[15:8];
            9'd1:    hdr_b = i_cmd.tid[7:0];
            9'd5:    hdr_b = plen;
            9'd6:    hdr_b = i_cmd.unit;
            9'd7:    hdr_b = i_cmd.fc;
            9'd8:    hdr_b = is_read ? i_cmd.nb : i_cmd.addr[15:8];
            9'd9:    hdr_b = i_cmd.addr[7:0];
            9'd10:   hdr_b = (i_cmd.fc == FC_WR_COIL) ? {8{i_cmd.coil}} : i_cmd.qty[15:8];
            9'd11:   hdr_b = (i_cmd.fc == FC_WR_COIL) ? 8'h00 : i_cmd.qty[7:0];
            default: hdr_b = 8'h00;
        endcase
    end

    always_comb begin
        n_state = r_state;  n_clr = r_clr;  n_ptr = r_ptr;  n_rem = r_rem;
        n_fp = r_fp;  n_bno = r_bno;  n_c = r_c;  n_bits = r_bits;  n_hi = r_hi;
        n_k = r_k;  n_n = r_n;
        b_we = 1'b0;  b_wa = r_ptr;  b_wd = 1'b0;  b_re = 1'b0;  b_ra = r_ptr;
        w_we = 1'b0;  w_wa = r_ptr;  w_wd = '0;    w_re = 1'b0;  w_ra = r_ptr;
        put_en = 1'b0;  put_b = '0;  pop = 1'b0;  rd_en = 1'b0;  bitv = 1'b0;

        unique case (r_state)
            S_CLR: begin
                b_we = 1'b1;  b_wa = r_clr;
                w_we = 1'b1;  w_wa = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(STORE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_ptr = i_cmd.addr[AW-1:0];
                    n_rem = i_cmd.qty[CNT_W-1:0];
                    n_fp  = FIW'(HDR_BYTES);
                    n_k   = '0;
                    n_bno = '0;
                    n_n   = is_read ? {1'b0, i_cmd.nb} + 9'd9 : 9'd12;
                    n_state = S_HDR;
                    unique case (i_cmd.fc)
                        FC_WR_COIL: begin
                            b_we = 1'b1;  b_wa = i_cmd.addr[AW-1:0];  b_wd = i_cmd.coil;
                        end
                        FC_WR_REG: begin
                            w_we = 1'b1;  w_wa = i_cmd.addr[AW-1:0];  w_wd = i_cmd.qty;
                        end
                        FC_WR_COILS: if (i_cmd.qty != 16'd0) n_state = S_W15_RD;
                        FC_WR_REGS:  if (i_cmd.qty != 16'd0) n_state = S_W16_HI;
                        default: ;
                    endcase
                end
            end
            S_W15_RD: begin
                rd_en = 1'b1;  n_fp = r_fp + 1'b1;  n_state = S_W15_BT;
            end
            S_W15_BT: begin
                b_we = 1'b1;  b_wd = i_frame_q[r_bno];
                n_ptr = r_ptr + 1'b1;  n_rem = r_rem - 1'b1;  n_bno = r_bno + 1'b1;
                if (r_rem == CNT_W'(1))   n_state = S_HDR;
                else if (r_bno == 3'd7)   n_state = S_W15_RD;
            end
            S_W16_HI: begin
                rd_en = 1'b1;  n_fp = r_fp + 1'b1;  n_state = S_W16_LO;
            end
            S_W16_LO: begin
                rd_en = 1'b1;  n_fp = r_fp + 1'b1;  n_hi = i_frame_q;  n_state = S_W16_WR;
            end
            S_W16_WR: begin
                w_we = 1'b1;  w_wd = {r_hi, i_frame_q};
                n_ptr = r_ptr + 1'b1;  n_rem = r_rem - 1'b1;
                n_state = (r_rem == CNT_W'(1)) ? S_HDR : S_W16_HI;
            end
            S_HDR: begin
                put_en = 1'b1;  put_b = hdr_b;  n_k = r_k + 1'b1;
                n_c = '0;  n_bits = '0;
                if (put_last)                      n_state = S_DONE;
                else if (is_read && r_k == 9'd8)   n_state = is_bits ? S_RB : S_RW_REQ;
            end
            S_RB: begin
                // bit reads are pipelined: issue at c, absorb at c+1
                if (r_c != 4'd8) begin
                    b_re = 1'b1;  n_ptr = r_ptr + 1'b1;  n_c = r_c + 1'b1;
                end
                if (r_c != 4'd0) begin
                    bitv = r_bit_q && (r_rem != '0);
                    if (r_rem != '0) n_rem = r_rem - 1'b1;
                end
                if (r_c != 4'd0 && r_c != 4'd8) n_bits[3'(r_c - 4'd1)] = bitv;
                if (r_c == 4'd8) begin
                    put_en = 1'b1;  put_b = {bitv, r_bits[6:0]};
                    n_k = r_k + 1'b1;  n_c = '0;  n_bits = '0;
                    if (put_last) n_state = S_DONE;
                end
            end
            S_RW_REQ: begin
                w_re = 1'b1;  n_ptr = r_ptr + 1'b1;  n_state = S_RW_HI;
            end
            S_RW_HI: begin
                put_en = 1'b1;  put_b = r_word_q[15:8];  n_k = r_k + 1'b1;  n_state = S_RW_LO;
            end
            S_RW_LO: begin
                put_en = 1'b1;  put_b = r_word_q[7:0];  n_k = r_k + 1'b1;
                n_state = put_last ? S_DONE : S_RW_REQ;
            end
            S_DONE: begin
                pop = 1'b1;  n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // beat assembly, first byte at the top
    always_comb begin
        n_acc    = r_acc;
        n_acnt   = r_acnt;
        n_ovld   = 1'b0;
        n_obytes = r_obytes;
        n_ocnt   = r_ocnt;
        n_olast  = r_olast;
        if (put_en) begin
            n_acc[r_acnt] = put_b;
            if (r_acnt == 3'd7 || put_last) begin
                n_ovld  = 1'b1;
                n_ocnt  = {1'b0, r_acnt} + 4'd1;
                n_olast = put_last;
                for (int i = 0; i < 8; i++) n_obytes[63 - 8*i -: 8] = n_acc[i];
                for (int i = 0; i < 8; i++) n_acc[i] = '0;
                n_acnt = '0;
            end else begin
                n_acnt = r_acnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_acnt  <= '0;
            r_ovld  <= 1'b0;
            for (int i = 0; i < 8; i++) r_acc[i] <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_acnt  <= n_acnt;
            r_ovld  <= n_ovld;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;  r_rem <= n_rem;  r_fp <= n_fp;  r_bno <= n_bno;
        r_c <= n_c;  r_bits <= n_bits;  r_hi <= n_hi;  r_k <= n_k;  r_n <= n_n;
        r_obytes <= n_obytes;  r_ocnt <= n_ocnt;  r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (b_we) r_bmem[b_wa] <= b_wd;
        if (b_re) r_bit_q <= r_bmem[b_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_wmem[w_wa] <= w_wd;
        if (w_re) r_word_q <= r_wmem[w_ra];
    end

    assign o_rd_en        = rd_en;
    assign o_rd_addr      = {i_cmd.bank, r_fp};
    assign o_sts.clearing = (r_state == S_CLR);
    assign o_sts.pop      = pop;
    assign o_reply_valid  = r_ovld;
    assign o_reply_bytes  = r_obytes;
    assign o_reply_count  = r_ocnt;
    assign o_reply_last   = r_olast;

endmodule
